[rtl/jackknife_min_pearson_correlation_core_defines.svh]
// Assertion macros shared by the checker files.
`ifndef JACKKNIFE_MIN_PEARSON_CORRELATION_CORE_DEFINES_SVH
`define JACKKNIFE_MIN_PEARSON_CORRELATION_CORE_DEFINES_SVH

// Checked only while out of reset.
`define JMPC_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked on every edge, reset included.
`define JMPC_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);

`endif

[rtl/jmpc_pkg.sv]
// Types and constants of the jackknife minimum Pearson correlation core.
package jmpc_pkg;

  localparam int SUM_W      = 64;
  localparam int PROD_W     = 128;
  localparam int MAG_W      = 15;
  localparam int RHS_SHIFT  = 28;
  localparam int MINV_W     = 7;
  localparam int THR_W      = 15;
  localparam int CFG_ADDR_W = 4;
  localparam int CFG_DATA_W = 32;
  localparam int OUT_DATA_W = 24;
  localparam int CORR_W     = 16;
  localparam int VP_W       = 7;

  localparam logic [MAG_W-1:0]  Q_ONE       = 15'd16384;
  localparam logic [MINV_W-1:0] MINV_RESET  = 7'd7;
  localparam logic [THR_W-1:0]  THR_RESET   = 15'd9830;

  localparam logic [CFG_ADDR_W-1:0] ADDR_LOO  = 4'h0;
  localparam logic [CFG_ADDR_W-1:0] ADDR_MINV = 4'h4;
  localparam logic [CFG_ADDR_W-1:0] ADDR_THR  = 4'h8;

  typedef enum logic [3:0] {
    MS_NSXX, MS_SXSX, MS_NSYY, MS_SYSY, MS_NSXY, MS_SXSY, MS_CC, MS_VXVY, MS_PK
  } mul_sel_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_START, ST_READ, ST_SETUP, ST_MUL_GO, ST_MUL_WAIT,
    ST_CHECK, ST_SEARCH, ST_DECIDE, ST_NEXT, ST_OUT
  } state_t;

  typedef struct packed {
    logic     load;
    logic     start;
    logic     rd;
    logic     setup;
    logic     mul_go;
    mul_sel_t sel;
    logic     search_step;
    logic     decide;
    logic     idx_inc;
    logic     emit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic mul_done;
    logic var_zero;
    logic search_open;
    logic out_free;
    logic store_empty;
    logic last_idx;
  } dp_stat_t;

endpackage

[rtl/jackknife_min_pearson_correlation_core.sv]
// Top level of the jackknife minimum Pearson correlation core.
//
//  channel  dir  handshake           payload
//  s_       in   s_tvalid/s_tready   s_tdata {y_sample, x_sample}, s_tuser {y_missing,
//                                    x_missing}, s_tlast
//  m_       out  m_tvalid/m_tready   m_tdata {valid_points, correlation}, m_tuser
//                                    {significant, undefined}
//  apb      in   psel/penable/pready registers at 0x0, 0x4, 0x8
//
// Words load one per cycle while the core is idle; it takes none while a frame is
// processed. After the last word each case (one, or one per stored position in
// leave-one-out mode) runs up to 23 serial multiplies in the shared shift-add unit,
// each stepping through its second operand bit by bit. Reset is synchronous and takes
// no clearing pass. m_tvalid holds with its word until m_tready; loading resumes
// while the result waits.
module jackknife_min_pearson_correlation_core #(
  parameter int MAX_SAMPLES  = 64,
  parameter int SAMPLE_WIDTH = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  input  logic [((2*SAMPLE_WIDTH+7)/8)*8-1:0] s_tdata,  // x_sample, y_sample
  input  logic [1:0]                          s_tuser,  // x_missing, y_missing
  input  logic                                s_tlast,
  output logic                                m_tvalid,
  input  logic                                m_tready,
  output logic [jmpc_pkg::OUT_DATA_W-1:0]     m_tdata,  // correlation, valid_points
  output logic [1:0]                          m_tuser,  // undefined, significant
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [jmpc_pkg::CFG_ADDR_W-1:0]     paddr,
  input  logic [jmpc_pkg::CFG_DATA_W-1:0]     pwdata,
  output logic [jmpc_pkg::CFG_DATA_W-1:0]     prdata,
  output logic                                pready
);
  import jmpc_pkg::*;

  logic                 skip_mode;
  logic [MINV_W-1:0]    min_valid_points;
  logic [THR_W-1:0]     significance_threshold;
  ctrl_cmd_t            cmd;
  dp_stat_t             stat;
  logic signed [CORR_W-1:0] correlation;
  logic [VP_W-1:0]      valid_points;
  logic                 undefined, significant;

  jmpc_cfg u_cfg (
    .clk                    (clk),
    .rst                    (rst),
    .psel                   (psel),
    .penable                (penable),
    .pwrite                 (pwrite),
    .paddr                  (paddr),
    .pwdata                 (pwdata),
    .prdata                 (prdata),
    .pready                 (pready),
    .skip_mode              (skip_mode),
    .min_valid_points       (min_valid_points),
    .significance_threshold (significance_threshold)
  );

  jmpc_ctrl u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (s_tvalid),
    .in_last       (s_tlast),
    .skip_mode     (skip_mode),
    .stat          (stat),
    .in_ready      (s_tready),
    .cmd           (cmd)
  );

  jmpc_dp #(
    .MAX_SAMPLES  (MAX_SAMPLES),
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
  ) u_dp (
    .clk                    (clk),
    .rst                    (rst),
    .cmd                    (cmd),
    .x_sample               (s_tdata[SAMPLE_WIDTH-1:0]),
    .y_sample               (s_tdata[2*SAMPLE_WIDTH-1:SAMPLE_WIDTH]),
    .x_missing              (s_tuser[0]),
    .y_missing              (s_tuser[1]),
    .skip_mode              (skip_mode),
    .min_valid_points       (min_valid_points),
    .significance_threshold (significance_threshold),
    .out_ready              (m_tready),
    .stat                   (stat),
    .out_valid              (m_tvalid),
    .correlation            (correlation),
    .valid_points           (valid_points),
    .undefined              (undefined),
    .significant            (significant)
  );

  assign m_tdata = {1'b0, valid_points, correlation};
  assign m_tuser = {significant, undefined};

endmodule

[rtl/jmpc_mul.sv]
// Shift-add multiplier, one bit of the second operand per cycle, product mod 2^128.
module jmpc_mul (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        go,
  input  logic [jmpc_pkg::PROD_W-1:0] a,
  input  logic [jmpc_pkg::SUM_W-1:0]  b,
  output logic                        done,
  output logic [jmpc_pkg::PROD_W-1:0] prod
);
  import jmpc_pkg::*;

  logic              busy;
  logic [PROD_W-1:0] acc;
  logic [PROD_W-1:0] ar;
  logic [SUM_W-1:0]  br;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (go) begin
      busy <= 1'b1;
    end else if (busy && br == '0) begin
      busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      acc <= '0;
      ar  <= a;
      br  <= b;
    end else if (busy && br != '0) begin
      if (br[0]) begin
        acc <= acc + ar;
      end
      ar <= ar << 1;
      br <= br >> 1;
    end
  end

  assign done = busy && (br == '0);
  assign prod = acc;

endmodule

[rtl/jmpc_cfg.sv]
// APB register file: mode, minimum point count and significance threshold.
module jmpc_cfg (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [jmpc_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [jmpc_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [jmpc_pkg::CFG_DATA_W-1:0] prdata,
  output logic                            pready,
  output logic                            skip_mode,
  output logic [jmpc_pkg::MINV_W-1:0]     min_valid_points,
  output logic [jmpc_pkg::THR_W-1:0]      significance_threshold
);
  import jmpc_pkg::*;

  logic wr;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      skip_mode              <= 1'b0;
      min_valid_points       <= MINV_RESET;
      significance_threshold <= THR_RESET;
    end else if (wr) begin
      unique case (paddr)
        ADDR_LOO:  skip_mode              <= pwdata[0];
        ADDR_MINV: min_valid_points       <= pwdata[MINV_W-1:0];
        ADDR_THR:  significance_threshold <= pwdata[THR_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr)
      ADDR_LOO:  prdata = CFG_DATA_W'(skip_mode);
      ADDR_MINV: prdata = CFG_DATA_W'(min_valid_points);
      ADDR_THR:  prdata = CFG_DATA_W'(significance_threshold);
      default:   prdata = '0;
    endcase
  end

endmodule

[rtl/jmpc_ctrl.sv]
// Controller: loads words, then sequences each case through sums, multiplies and root search.
module jmpc_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  input  logic                  in_last,
  input  logic                  skip_mode,
  input  jmpc_pkg::dp_stat_t    stat,
  output logic                  in_ready,
  output jmpc_pkg::ctrl_cmd_t   cmd
);
  import jmpc_pkg::*;

  state_t   state, state_next;
  mul_sel_t sel, sel_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      sel   <= MS_NSXX;
    end else begin
      state <= state_next;
      sel   <= sel_next;
    end
  end

  always_comb begin
    state_next = state;
    sel_next   = sel;
    cmd        = '0;
    cmd.sel    = sel;
    in_ready   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
        if (in_valid && in_last) begin
          state_next = ST_START;
        end
      end
      ST_START: begin
        cmd.start = 1'b1;
        if (!skip_mode) begin
          state_next = ST_SETUP;
        end else if (stat.store_empty) begin
          state_next = ST_OUT;
        end else begin
          state_next = ST_READ;
        end
      end
      ST_READ: begin
        cmd.rd     = 1'b1;
        state_next = ST_SETUP;
      end
      ST_SETUP: begin
        cmd.setup  = 1'b1;
        sel_next   = MS_NSXX;
        state_next = ST_MUL_GO;
      end
      ST_MUL_GO: begin
        cmd.mul_go = 1'b1;
        state_next = ST_MUL_WAIT;
      end
      ST_MUL_WAIT: begin
        if (stat.mul_done) begin
          state_next = ST_MUL_GO;
          unique case (sel)
            MS_NSXX: sel_next = MS_SXSX;
            MS_SXSX: sel_next = MS_NSYY;
            MS_NSYY: sel_next = MS_SYSY;
            MS_SYSY: state_next = ST_CHECK;
            MS_NSXY: sel_next = MS_SXSY;
            MS_SXSY: sel_next = MS_CC;
            MS_CC:   sel_next = MS_VXVY;
            MS_VXVY: state_next = ST_SEARCH;
            MS_PK:   state_next = ST_SEARCH;
            default: state_next = ST_SEARCH;
          endcase
        end
      end
      ST_CHECK: begin
        if (stat.var_zero) begin
          state_next = ST_NEXT;
        end else begin
          sel_next   = MS_NSXY;
          state_next = ST_MUL_GO;
        end
      end
      ST_SEARCH: begin
        if (stat.search_open) begin
          cmd.search_step = 1'b1;
          sel_next        = MS_PK;
          state_next      = ST_MUL_GO;
        end else begin
          state_next = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        cmd.decide = 1'b1;
        state_next = ST_NEXT;
      end
      ST_NEXT: begin
        if (!skip_mode || stat.last_idx) begin
          state_next = ST_OUT;
        end else begin
          cmd.idx_inc = 1'b1;
          state_next  = ST_READ;
        end
      end
      ST_OUT: begin
        if (stat.out_free) begin
          cmd.emit   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule

[rtl/jmpc_dp.sv]
// Datapath: sample store, running sums, per-case moments, root search and result register.
module jmpc_dp #(
  parameter int MAX_SAMPLES  = 64,
  parameter int SAMPLE_WIDTH = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  input  jmpc_pkg::ctrl_cmd_t                 cmd,
  input  logic signed [SAMPLE_WIDTH-1:0]      x_sample,
  input  logic signed [SAMPLE_WIDTH-1:0]      y_sample,
  input  logic                                x_missing,
  input  logic                                y_missing,
  input  logic                                skip_mode,
  input  logic [jmpc_pkg::MINV_W-1:0]         min_valid_points,
  input  logic [jmpc_pkg::THR_W-1:0]          significance_threshold,
  input  logic                                out_ready,
  output jmpc_pkg::dp_stat_t                  stat,
  output logic                                out_valid,
  output logic signed [jmpc_pkg::CORR_W-1:0]  correlation,
  output logic [jmpc_pkg::VP_W-1:0]           valid_points,
  output logic                                undefined,
  output logic                                significant
);
  import jmpc_pkg::*;

  localparam int AW    = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;
  localparam int CW    = $clog2(MAX_SAMPLES + 1);
  localparam int CMP_W = (CW > MINV_W) ? CW : MINV_W;
  localparam int PW    = 2 * SAMPLE_WIDTH;

  logic [SAMPLE_WIDTH-1:0] x_mem [MAX_SAMPLES];
  logic [SAMPLE_WIDTH-1:0] y_mem [MAX_SAMPLES];
  logic                    m_mem [MAX_SAMPLES];
  logic [SAMPLE_WIDTH-1:0] x_rd, y_rd;
  logic                    m_rd;

  logic [CW-1:0]    count, fn, idx, n;
  logic [SUM_W-1:0] fsx, fsy, fsxx, fsyy, fsxy;
  logic [SUM_W-1:0] sx, sy, sxx, syy, sxy;
  logic [SUM_W-1:0] t, vx, vy, cm;
  logic             cneg;
  logic [PROD_W-1:0] rhs, p;
  logic [MAG_W-1:0]  lo, hi, mid;
  logic [2*MAG_W-1:0] k2;
  logic             found, best_neg;
  logic [MAG_W-1:0] best_mag;
  logic [CW-1:0]    best_n;
  mul_sel_t         sel_q;

  logic             room, miss_in, drop;
  logic signed [PW-1:0] ixx, iyy, ixy, rxx, ryy, rxy;
  logic [SUM_W-1:0] ixe, iye, rxe, rye;
  logic [PROD_W-1:0] mul_a, mul_prod;
  logic [SUM_W-1:0]  mul_b, diff, cm_c;
  logic              mul_done;
  logic [MAG_W:0]    mid_sum;
  logic [MAG_W-1:0]  mid_c;
  logic              take;
  logic [CMP_W-1:0]  npts_w, minv_w;
  logic [CW-1:0]     npts;

  assign room    = count < CW'(MAX_SAMPLES);
  assign miss_in = x_missing | y_missing;
  assign ixx = x_sample * x_sample;
  assign iyy = y_sample * y_sample;
  assign ixy = x_sample * y_sample;
  assign ixe = SUM_W'(x_sample);
  assign iye = SUM_W'(y_sample);

  always_ff @(posedge clk) begin
    if (cmd.load && room) begin
      x_mem[count[AW-1:0]] <= x_sample;
      y_mem[count[AW-1:0]] <= y_sample;
      m_mem[count[AW-1:0]] <= miss_in;
    end
    if (cmd.rd) begin
      x_rd <= x_mem[idx[AW-1:0]];
      y_rd <= y_mem[idx[AW-1:0]];
      m_rd <= m_mem[idx[AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.emit) begin
      count <= '0;
      fn    <= '0;
      fsx   <= '0;
      fsy   <= '0;
      fsxx  <= '0;
      fsyy  <= '0;
      fsxy  <= '0;
    end else if (cmd.load && room) begin
      count <= count + 1'b1;
      if (!miss_in) begin
        fn   <= fn + 1'b1;
        fsx  <= fsx + ixe;
        fsy  <= fsy + iye;
        fsxx <= fsxx + SUM_W'(ixx);
        fsyy <= fsyy + SUM_W'(iyy);
        fsxy <= fsxy + SUM_W'(ixy);
      end
    end
  end

  assign rxx  = $signed(x_rd) * $signed(x_rd);
  assign ryy  = $signed(y_rd) * $signed(y_rd);
  assign rxy  = $signed(x_rd) * $signed(y_rd);
  assign rxe  = SUM_W'($signed(x_rd));
  assign rye  = SUM_W'($signed(y_rd));
  assign drop = skip_mode && !m_rd;

  always_ff @(posedge clk) begin
    if (cmd.setup) begin
      if (drop) begin
        n   <= fn - 1'b1;
        sx  <= fsx - rxe;
        sy  <= fsy - rye;
        sxx <= fsxx - SUM_W'(rxx);
        syy <= fsyy - SUM_W'(ryy);
        sxy <= fsxy - SUM_W'(rxy);
      end else begin
        n   <= fn;
        sx  <= fsx;
        sy  <= fsy;
        sxx <= fsxx;
        syy <= fsyy;
        sxy <= fsxy;
      end
    end
  end

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd.sel)
      MS_NSXX: begin mul_a = PROD_W'(sxx); mul_b = SUM_W'(n);  end
      MS_SXSX: begin mul_a = PROD_W'(sx);  mul_b = sx;         end
      MS_NSYY: begin mul_a = PROD_W'(syy); mul_b = SUM_W'(n);  end
      MS_SYSY: begin mul_a = PROD_W'(sy);  mul_b = sy;         end
      MS_NSXY: begin mul_a = PROD_W'(sxy); mul_b = SUM_W'(n);  end
      MS_SXSY: begin mul_a = PROD_W'(sx);  mul_b = sy;         end
      MS_CC:   begin mul_a = PROD_W'(cm);  mul_b = cm;         end
      MS_VXVY: begin mul_a = PROD_W'(vx);  mul_b = vy;         end
      MS_PK:   begin mul_a = p;            mul_b = SUM_W'(k2); end
      default: ;
    endcase
  end

  jmpc_mul u_mul (
    .clk  (clk),
    .rst  (rst),
    .go   (cmd.mul_go),
    .a    (mul_a),
    .b    (mul_b),
    .done (mul_done),
    .prod (mul_prod)
  );

  assign diff = t - mul_prod[SUM_W-1:0];
  assign cm_c = diff[SUM_W-1] ? (~diff + 1'b1) : diff;

  always_ff @(posedge clk) begin
    if (cmd.mul_go) begin
      sel_q <= cmd.sel;
    end
    if (mul_done) begin
      case (sel_q) inside
        MS_NSXX, MS_NSYY, MS_NSXY: t <= mul_prod[SUM_W-1:0];
        MS_SXSX: vx <= diff;
        MS_SYSY: vy <= diff;
        MS_SXSY: begin
          cneg <= diff[SUM_W-1];
          cm   <= cm_c;
        end
        MS_CC:   rhs <= mul_prod << RHS_SHIFT;
        MS_VXVY: begin
          p  <= mul_prod;
          lo <= '0;
          hi <= Q_ONE;
        end
        MS_PK: begin
          if (mul_prod <= rhs) begin
            lo <= mid;
          end else begin
            hi <= mid - 1'b1;
          end
        end
        default: ;
      endcase
    end
    if (cmd.search_step) begin
      mid <= mid_c;
      k2  <= mid_c * mid_c;
    end
  end

  assign mid_sum = {1'b0, lo} + {1'b0, hi} + 1'b1;
  assign mid_c   = mid_sum[MAG_W:1];

  assign minv_w = CMP_W'(min_valid_points);
  assign take   = !skip_mode ||
                  (CMP_W'(n) >= minv_w && (!found || lo < best_mag));

  always_ff @(posedge clk) begin
    if (rst || cmd.start) begin
      found <= 1'b0;
      idx   <= '0;
    end else begin
      if (cmd.idx_inc) begin
        idx <= idx + 1'b1;
      end
      if (cmd.decide && take) begin
        found <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.decide && take) begin
      best_mag <= lo;
      best_neg <= cneg && (lo != '0);
      best_n   <= n;
    end
  end

  assign npts   = skip_mode ? (found ? best_n : '0) : (found ? best_n : n);
  assign npts_w = CMP_W'(npts);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      if (!found) begin
        correlation <= '0;
      end else if (best_neg) begin
        correlation <= -$signed({1'b0, best_mag});
      end else begin
        correlation <= $signed({1'b0, best_mag});
      end
      valid_points <= npts_w[VP_W-1:0];
      undefined    <= !found;
      significant  <= found && !best_neg && (npts_w >= minv_w) &&
                      (best_mag >= significance_threshold);
    end
  end

  assign stat.mul_done    = mul_done;
  assign stat.var_zero    = (vx == '0) || (vy == '0);
  assign stat.search_open = lo < hi;
  assign stat.out_free    = !out_valid || out_ready;
  assign stat.store_empty = (count == '0);
  assign stat.last_idx    = (idx == count - 1'b1);

endmodule

[rtl/jmpc_checker.sv]
// Port-level checks on the result channel, bound to the top level.
`include "jackknife_min_pearson_correlation_core_defines.svh"

module jmpc_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            m_tvalid,
  input logic                            m_tready,
  input logic [jmpc_pkg::OUT_DATA_W-1:0] m_tdata,
  input logic [1:0]                      m_tuser
);

  `JMPC_ASSERT_ALWAYS(a_reset_empty, rst |=> !m_tvalid, "result valid after reset")

  `JMPC_ASSERT(a_stall_hold, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser), "stalled word changed")

  `JMPC_ASSERT(a_undef_zero, m_tvalid && m_tuser[0] |-> m_tdata[15:0] == 16'd0 && !m_tuser[1], "undefined result not cleared")

  `JMPC_ASSERT(a_sig_positive, m_tvalid && m_tuser[1] |-> !m_tdata[15] && !m_tuser[0], "significant result negative or undefined")

endmodule

bind jackknife_min_pearson_correlation_core jmpc_checker u_jmpc_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);

[tb/sv/jackknife_min_pearson_correlation_core_test.sv]
// Testbench for the jackknife minimum Pearson correlation core with a self-checking predictor.
module jackknife_min_pearson_correlation_core_test;
  import jmpc_pkg::*;

  localparam int NSAMP = 64;
  localparam int CYCLE_LIMIT = 4000000;

  typedef struct {
    bit [15:0] corr;
    bit [6:0]  npts;
    bit        undef;
    bit        sig;
  } corr_result_t;

  logic        clk = 0;
  logic        rst = 1;
  logic        s_tvalid = 0;
  logic        s_tready;
  logic [31:0] s_tdata = '0;
  logic [1:0]  s_tuser = '0;
  logic        s_tlast = 0;
  logic        m_tvalid;
  logic        m_tready = 0;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic [1:0]  m_tuser;
  logic        psel = 0;
  logic        penable = 0;
  logic        pwrite = 0;
  logic [CFG_ADDR_W-1:0] paddr = '0;
  logic [CFG_DATA_W-1:0] pwdata = '0;
  logic [CFG_DATA_W-1:0] prdata;
  logic        pready;

  jackknife_min_pearson_correlation_core uut (.*);

  // predictor state
  longint unsigned xs [NSAMP];
  longint unsigned ys [NSAMP];
  bit              miss [NSAMP];
  int              count;
  bit              loo_mode;
  bit [6:0]        min_pts;
  bit [14:0]       thr;

  corr_result_t expected_q[$];
  int  errors;
  int  cycles;
  int  tx_idle;
  int  rx_idle;
  bit  hold_req;

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("jackknife_min_pearson_correlation_core: mismatch");
      $finish;
    end
  end

  // receiver: random stalls, plus one long hold on request
  initial begin
    forever begin
      @(negedge clk);
      if (hold_req) begin
        m_tready <= 0;
        repeat (3000) @(negedge clk);
        hold_req = 0;
      end else begin
        m_tready <= ($urandom_range(99) >= rx_idle);
      end
    end
  end

  always @(posedge clk) begin
    corr_result_t e;
    if (!rst && m_tvalid && m_tready) begin
      if (expected_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected word %h/%b", m_tdata, m_tuser);
      end else begin
        e = expected_q.pop_front();
        if (m_tdata[15:0] !== e.corr || m_tdata[22:16] !== e.npts ||
            m_tuser[0] !== e.undef || m_tuser[1] !== e.sig) begin
          errors++;
          if (errors <= 10)
            $display("exp corr %0d pts %0d undef %b sig %b, got corr %0d pts %0d undef %b sig %b",
                     $signed(e.corr), e.npts, e.undef, e.sig, $signed(m_tdata[15:0]),
                     m_tdata[22:16], m_tuser[0], m_tuser[1]);
        end
      end
    end
  end

  function automatic bit pearson_case(int skip, output int npts, output int mag,
                                      output bit neg);
    longint unsigned n, sx, sy, sxx, syy, sxy, vx, vy, c, cm;
    bit [127:0] rhs, lhs;
    int lo, hi, mid, i;
    n = 0; sx = 0; sy = 0; sxx = 0; syy = 0; sxy = 0;
    for (i = 0; i < count; i++) begin
      if (i == skip || miss[i]) continue;
      n++;
      sx += xs[i];
      sy += ys[i];
      sxx += xs[i] * xs[i];
      syy += ys[i] * ys[i];
      sxy += xs[i] * ys[i];
    end
    npts = int'(n);
    mag = 0;
    neg = 0;
    vx = n * sxx - sx * sx;
    vy = n * syy - sy * sy;
    if (vx == 0 || vy == 0) return 0;
    c = n * sxy - sx * sy;
    cm = c[63] ? (64'd0 - c) : c;
    rhs = ({64'd0, cm} * {64'd0, cm}) << RHS_SHIFT;
    lo = 0;
    hi = 16384;
    while (lo < hi) begin
      mid = (lo + hi + 1) / 2;
      lhs = ({64'd0, 64'(mid * mid)} * {64'd0, vx}) * {64'd0, vy};
      if (lhs <= rhs) lo = mid;
      else hi = mid - 1;
    end
    mag = lo;
    neg = c[63] && lo != 0;
    return 1;
  endfunction

  function automatic void predict_word(bit [15:0] x, bit [15:0] y, bit xm, bit ym, bit lst);
    corr_result_t r;
    bit found, neg, s, d;
    int mag, npts, n, m, i;
    if (count < NSAMP) begin
      xs[count] = longint'($signed(x));
      ys[count] = longint'($signed(y));
      miss[count] = xm | ym;
      count++;
    end
    if (!lst) return;
    found = 0; neg = 0; mag = 0; npts = 0;
    if (loo_mode) begin
      for (i = 0; i < count; i++) begin
        d = pearson_case(i, n, m, s);
        if (!d || n < min_pts) continue;
        if (!found || m < mag) begin
          found = 1; mag = m; neg = s; npts = n;
        end
      end
    end else begin
      found = pearson_case(NSAMP + 1, npts, mag, neg);
    end
    r.corr = !found ? 16'd0 : neg ? 16'(-mag) : 16'(mag);
    r.npts = (loo_mode && !found) ? 7'd0 : 7'(npts);
    r.undef = !found;
    r.sig = found && !neg && npts >= min_pts && mag >= thr;
    expected_q = {expected_q, r};
    count = 0;
  endfunction

  task automatic send_word(bit [15:0] x, bit [15:0] y, bit xm, bit ym, bit lst);
    while ($urandom_range(99) < tx_idle) begin
      @(negedge clk);
      s_tvalid <= 0;
    end
    @(negedge clk);
    s_tvalid <= 1;
    s_tdata <= {y, x};
    s_tuser <= {ym, xm};
    s_tlast <= lst;
    do @(posedge clk); while (!s_tready);
    predict_word(x, y, xm, ym, lst);
  endtask

  task automatic drain;
    @(negedge clk);
    s_tvalid <= 0;
    wait (expected_q.size() == 0);
    repeat (50) @(posedge clk);
  endtask

  task automatic apb_write(logic [CFG_ADDR_W-1:0] addr, logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    psel <= 1;
    pwrite <= 1;
    paddr <= addr;
    pwdata <= data;
    @(negedge clk);
    penable <= 1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel <= 0;
    penable <= 0;
    pwrite <= 0;
    case (addr)
      ADDR_LOO:  loo_mode = data[0];
      ADDR_MINV: min_pts = data[6:0];
      ADDR_THR:  thr = data[14:0];
      default: ;
    endcase
  endtask

  task automatic configure(bit loo, int minv, int th);
    drain();
    apb_write(ADDR_LOO, 32'(loo));
    apb_write(ADDR_MINV, minv);
    apb_write(ADDR_THR, th);
  endtask

  task automatic random_frame(int len);
    int kind, i;
    bit [15:0] x, y;
    kind = $urandom_range(9);
    for (i = 0; i < len; i++) begin
      x = (kind == 0) ? 16'h1234 : 16'($urandom);
      case (kind)
        1, 2, 3: y = x + 16'($urandom_range(255)) - 16'd128;
        4, 5:    y = -x + 16'($urandom_range(4095)) - 16'd2048;
        6:       y = 16'($urandom_range(7)) - 16'd4;
        default: y = 16'($urandom);
      endcase
      send_word(x, y, $urandom_range(11) == 0, $urandom_range(11) == 0, i == len - 1);
    end
  endtask

  task automatic test_directed_plain;
    int i;
    configure(0, 7, 9830);
    for (i = 0; i < 8; i++)  // full-scale perfect correlation
      send_word(i[0] ? 16'h7fff : 16'h8000, i[0] ? 16'h7fff : 16'h8000, 0, 0, i == 7);
    for (i = 0; i < 8; i++)  // perfect anticorrelation
      send_word(16'(i * 100), 16'(-i * 100), 0, 0, i == 7);
    send_word(16'd5, 16'd9, 0, 0, 1);  // single pair
    for (i = 0; i < 4; i++)  // zero variance
      send_word(16'd77, 16'(i), 0, 0, i == 3);
    for (i = 0; i < 4; i++)
      send_word(16'(i), 16'(i * 3), i == 1, i == 2, i == 3);
  endtask

  task automatic test_directed_loo;
    int i;
    configure(1, 3, 0);
    for (i = 0; i < 5; i++)
      send_word(16'(i * 1000), 16'(i * i * 50), 0, 0, i == 4);
    configure(1, 64, 16384);  // nothing qualifies
    for (i = 0; i < 4; i++)
      send_word(16'($urandom), 16'($urandom), 0, 0, i == 3);
    configure(1, 0, 32767);  // below the usual minimum
    for (i = 0; i < 4; i++)
      send_word(16'($urandom), 16'($urandom), i == 0, 0, i == 3);
  endtask

  task automatic test_store_full;
    int i;
    configure(0, 64, 100);
    for (i = 0; i < 70; i++)
      send_word(16'($urandom), 16'($urandom_range(65535)), 0, 0, i == 69);
  endtask

  task automatic test_backpressure;
    int i;
    configure(0, 3, 9830);
    @(posedge clk);
    hold_req = 1;
    for (i = 0; i < 12; i++) random_frame(3);
  endtask

  task automatic test_random;
    int phase, sent, len;
    int settings [8][3] = '{'{0, 7, 9830}, '{1, 3, 0}, '{0, 64, 16384}, '{1, 2, 5000},
                            '{0, 3, 0}, '{1, 4, 9830}, '{0, 0, 32767}, '{1, 3, 12000}};
    for (phase = 0; phase < 8; phase++) begin
      case (phase % 3)
        0: begin tx_idle = 26; rx_idle = 65; end
        1: begin tx_idle = 65; rx_idle = 26; end
        default: begin tx_idle = 0; rx_idle = 0; end
      endcase
      configure(settings[phase][0] != 0, settings[phase][1], settings[phase][2]);
      sent = 0;
      while (sent < 95) begin
        len = settings[phase][0] ? $urandom_range(2, 6) : $urandom_range(2, 12);
        random_frame(len);
        sent += len;
      end
    end
    tx_idle = 0;
    rx_idle = 0;
  endtask

  initial begin
    count = 0;
    loo_mode = 0;
    min_pts = MINV_RESET;
    thr = THR_RESET;
    errors = 0;
    cycles = 0;
    tx_idle = 0;
    rx_idle = 0;
    hold_req = 0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 0;
    for (int i = 0; i < 6; i++)  // reset defaults
      send_word(16'(i * 9), 16'(i * 7 + i * i), 0, 0, i == 5);
    test_directed_plain();
    test_directed_loo();
    test_store_full();
    test_backpressure();
    test_random();
    drain();
    if (errors == 0) $display("jackknife_min_pearson_correlation_core: match");
    else $display("jackknife_min_pearson_correlation_core: mismatch");
    $finish;
  end

endmodule
